// ===== design/esds_pkg.sv =====
// Shared types, codes and constants for the elementary stream descriptor parser.
package esds_pkg;

    // Default width of the descriptor length and byte counters.
    localparam int LENGTH_BITS_DEF = 32;

    // Parse phases.
    localparam int PHASE_W = 3;
    typedef logic [PHASE_W-1:0] t_phase;
    localparam t_phase PH_TAG     = 3'd0;
    localparam t_phase PH_LEN     = 3'd1;
    localparam t_phase PH_SKIP    = 3'd2;
    localparam t_phase PH_PAYLOAD = 3'd3;
    localparam t_phase PH_DONE    = 3'd4;

    // Descriptor tags with special handling.
    localparam logic [7:0] TAG_ES_DESCR     = 8'd3;
    localparam logic [7:0] TAG_DEC_CFG      = 8'd4;
    localparam logic [7:0] TAG_DEC_SPECIFIC = 8'd5;

    // Fixed skip counts after the ES and decoder config headers.
    localparam int SKIP_ES_DESCR = 3;
    localparam int SKIP_DEC_CFG  = 13;

    // Length coding: seven data bits, bit seven flags another group.
    localparam logic [6:0] LEN_DATA_MASK = 7'h7f;
    localparam int         LEN_MORE_BIT  = 7;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_byte;
        logic       out_last;
        t_status    out_status;
    } t_out;

endpackage

// ===== design/esds_decoder_config_extractor_core.sv =====
// Top level of the elementary stream descriptor decoder configuration extractor.
//
// This block takes an MPEG-4 elementary stream descriptor one byte per request,
// with in_end set on the final byte of the blob, and returns the payload of the
// decoder specific configuration (tag 5) one byte per result. It accepts one
// byte every clock cycle unless a result is held up at a full result register;
// a byte passes from the input register through the step logic to the result
// register, from which its result is presented, and a byte whose result has no
// place to go waits in the input register. The header walk, skip counting and
// payload counting are all done in the single stage between those registers,
// so the throughput is set by that one stage and by how fast the consumer takes
// results. Bytes that produce no result (headers, skipped bytes, anything after
// the payload) flow through without using the result register. Every blob ends
// with exactly one result marked out_last: the final payload byte (marked
// truncated when the blob ends early on a payload byte), an empty result for a
// zero-length configuration, or an empty result whose out_status says not found
// or truncated.
module esds_decoder_config_extractor_core #(
    parameter int LENGTH_BITS = esds_pkg::LENGTH_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  esds_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output esds_pkg::t_out o_out
);
    import esds_pkg::*;

    // Input register stage.
    logic r_in_valid;
    t_in  r_in;

    // Parser state.
    t_phase                 r_phase;
    logic [7:0]             r_tag;
    logic [LENGTH_BITS-1:0] r_accum;
    logic [LENGTH_BITS-1:0] r_remain;

    // Result register.
    logic r_out_valid;
    t_out r_out;

    // Next-state values from the step logic.
    t_phase                 n_phase;
    logic [7:0]             n_tag;
    logic [LENGTH_BITS-1:0] n_accum;
    logic [LENGTH_BITS-1:0] n_remain;
    logic                   n_has_res;
    t_out                   n_res;

    logic adv;
    logic out_free;

    esds_step #(
        .LEN_BITS (LENGTH_BITS)
    ) u_step (
        .i_in      (r_in),
        .i_phase   (r_phase),
        .i_tag     (r_tag),
        .i_accum   (r_accum),
        .i_remain  (r_remain),
        .o_phase   (n_phase),
        .o_tag     (n_tag),
        .o_accum   (n_accum),
        .o_remain  (n_remain),
        .o_has_res (n_has_res),
        .o_res     (n_res)
    );

    // The result register can take a new result when it is empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // The buffered byte is processed when its result, if any, has a place to go.
    assign adv = r_in_valid && (!n_has_res || out_free);

    // A new request enters whenever the input register is empty or moving on.
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_tag    <= '0;
            r_accum  <= '0;
            r_remain <= '0;
        end else if (adv) begin
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_accum  <= n_accum;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && n_has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && n_has_res) begin
            r_out <= n_res;
        end
    end

    // A buffered byte that cannot move on stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("buffered byte lost while stalled");

    // The final byte of a blob always returns the parser to its reset state.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.in_end) |=> (r_phase == PH_TAG && r_accum == '0))
        else $error("parser not reset after final byte");

    // Only the closing result of a blob may be empty.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.out_has_byte) |-> (r_out.out_last && r_out.out_byte == 8'd0))
        else $error("empty result not marked last");

    // An error status only appears on the closing result.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_status != ST_OK) |-> r_out.out_last)
        else $error("error status on a result that is not last");

    // A result is never produced while the result register holds an untaken one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(adv && n_has_res))
        else $error("result register overwritten");

endmodule

// ===== design/esds_step.sv =====
// Next-state and result logic for one descriptor byte.
module esds_step #(
    parameter int LEN_BITS = esds_pkg::LENGTH_BITS_DEF
) (
    input  esds_pkg::t_in    i_in,
    input  esds_pkg::t_phase i_phase,
    input  logic [7:0]       i_tag,
    input  logic [LEN_BITS-1:0] i_accum,
    input  logic [LEN_BITS-1:0] i_remain,
    output esds_pkg::t_phase o_phase,
    output logic [7:0]       o_tag,
    output logic [LEN_BITS-1:0] o_accum,
    output logic [LEN_BITS-1:0] o_remain,
    output logic             o_has_res,
    output esds_pkg::t_out   o_res
);
    import esds_pkg::*;

    logic [LEN_BITS-1:0] len_new;
    logic [LEN_BITS-1:0] remain_dec;
    logic [LEN_BITS-1:0] skip_n;

    assign len_new    = LEN_BITS'({i_accum, i_in.in_byte[6:0] & LEN_DATA_MASK});
    assign remain_dec = i_remain - LEN_BITS'(1);

    always_comb begin
        priority if (i_tag == TAG_ES_DESCR) begin
            skip_n = LEN_BITS'(SKIP_ES_DESCR);
        end else if (i_tag == TAG_DEC_CFG) begin
            skip_n = LEN_BITS'(SKIP_DEC_CFG);
        end else begin
            skip_n = len_new;
        end
    end

    always_comb begin
        o_phase   = i_phase;
        o_tag     = i_tag;
        o_accum   = i_accum;
        o_remain  = i_remain;
        o_has_res = 1'b0;
        o_res     = '0;

        unique case (i_phase)
            PH_TAG: begin
                o_tag   = i_in.in_byte;
                o_accum = '0;
                o_phase = PH_LEN;
            end
            PH_LEN: begin
                o_accum = len_new;
                if (!i_in.in_byte[LEN_MORE_BIT]) begin
                    if (i_tag == TAG_DEC_SPECIFIC) begin
                        if (len_new == '0) begin
                            // Empty configuration: one empty result closes the blob.
                            o_has_res      = 1'b1;
                            o_res.out_last = 1'b1;
                            o_phase        = PH_DONE;
                        end else begin
                            o_remain = len_new;
                            o_phase  = PH_PAYLOAD;
                        end
                    end else if (skip_n == '0) begin
                        o_phase = PH_TAG;
                    end else begin
                        o_remain = skip_n;
                        o_phase  = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                o_remain = remain_dec;
                if (remain_dec == '0) begin
                    o_phase = PH_TAG;
                end
            end
            PH_PAYLOAD: begin
                o_remain           = remain_dec;
                o_has_res          = 1'b1;
                o_res.out_byte     = i_in.in_byte;
                o_res.out_has_byte = 1'b1;
                o_res.out_last     = (remain_dec == '0);
                if (remain_dec == '0) begin
                    o_phase = PH_DONE;
                end
            end
            default: begin
                o_phase = PH_DONE;
            end
        endcase

        // The final byte of a blob closes it and returns to the reset state.
        if (i_in.in_end) begin
            if (o_has_res) begin
                if (!o_res.out_last) begin
                    o_res.out_last   = 1'b1;
                    o_res.out_status = ST_TRUNCATED;
                end
            end else if (o_phase == PH_PAYLOAD) begin
                o_has_res        = 1'b1;
                o_res            = '0;
                o_res.out_last   = 1'b1;
                o_res.out_status = ST_TRUNCATED;
            end else if (o_phase != PH_DONE) begin
                o_has_res        = 1'b1;
                o_res            = '0;
                o_res.out_last   = 1'b1;
                o_res.out_status = ST_NOT_FOUND;
            end
            o_phase  = PH_TAG;
            o_tag    = '0;
            o_accum  = '0;
            o_remain = '0;
        end
    end

endmodule
